@@ src/timed_event_table_assert.svh @@
// Assertion macros for the timed event table.
// Included by RTL files that carry concurrent checks; depends on clk_i and rst_ni.
`ifndef TIMED_EVENT_TABLE_ASSERT_SVH
`define TIMED_EVENT_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define TET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TET_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
`else
`define TET_ASSERT(lbl, prop, msg)
`define TET_ASSERT_IMPL(lbl, pre, post, msg)
`endif
`endif

@@ src/tet_pkg.sv @@
// Shared codes and types for the timed event table.
// No dependencies.
`default_nettype none
package tet_pkg;
  localparam logic [2:0] MODE_ADD_ONE = 3'd0;
  localparam logic [2:0] MODE_ADD_REP = 3'd1;
  localparam logic [2:0] MODE_REMOVE  = 3'd2;
  localparam logic [2:0] MODE_TICK    = 3'd3;
  localparam logic [2:0] MODE_CLEAR   = 3'd4;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_BAD_IVL   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_FIRED     = 3'd5;
  localparam logic [2:0] ST_CLEARED   = 3'd6;

  typedef struct packed {
    logic shift;
    logic insert;
    logic clear;
  } cell_ctrl_t;
endpackage
`default_nettype wire

@@ src/tet_cell.sv @@
// One timer slot of the chain: holds an entry, loads from its upper neighbour or from the insert inputs.
// Depends on tet_pkg.
`default_nettype none
module tet_cell import tet_pkg::*; #(
  parameter int TIME_BITS = 48
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cell_ctrl_t           ctrl_i,
  input  wire logic                 nb_valid_i,
  input  wire logic                 nb_rep_i,
  input  wire logic [TIME_BITS-1:0] nb_due_i,
  input  wire logic [31:0]          nb_ivl_i,
  input  wire logic [15:0]          nb_bud_i,
  input  wire logic [31:0]          nb_id_i,
  input  wire logic                 ins_rep_i,
  input  wire logic [TIME_BITS-1:0] ins_due_i,
  input  wire logic [31:0]          ins_ivl_i,
  input  wire logic [15:0]          ins_bud_i,
  input  wire logic [31:0]          ins_id_i,
  output logic                      valid_o,
  output logic                      rep_o,
  output logic [TIME_BITS-1:0]      due_o,
  output logic [31:0]               ivl_o,
  output logic [15:0]               bud_o,
  output logic [31:0]               id_o
);
  logic                 valid_q;
  logic                 rep_q;
  logic [TIME_BITS-1:0] due_q;
  logic [31:0]          ivl_q;
  logic [15:0]          bud_q;
  logic [31:0]          id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= nb_valid_i;
    end else if (ctrl_i.insert) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      rep_q <= nb_rep_i;
      due_q <= nb_due_i;
      ivl_q <= nb_ivl_i;
      bud_q <= nb_bud_i;
      id_q  <= nb_id_i;
    end else if (ctrl_i.insert) begin
      rep_q <= ins_rep_i;
      due_q <= ins_due_i;
      ivl_q <= ins_ivl_i;
      bud_q <= ins_bud_i;
      id_q  <= ins_id_i;
    end
  end

  assign valid_o = valid_q;
  assign rep_o   = rep_q;
  assign due_o   = due_q;
  assign ivl_o   = ivl_q;
  assign bud_o   = bud_q;
  assign id_o    = id_q;
endmodule
`default_nettype wire

@@ src/timed_event_table.sv @@
// Timed event table: a chain of SLOTS timer cells kept in insertion order.
// Input channel (in_valid_i / in_stall_o) carries mode, now_ms, period_ms,
// repeat_budget and target_id; a transfer happens when valid is high and
// stall is low. Output channel (out_valid_o / out_stall_i) carries status,
// event_id and last_of_run, one result per transfer (per fired id for a tick).
// Add and clear update the table when accepted and deliver their result
// from the finish state. Remove and tick rotate the whole chain through the
// head cell, one slot per cycle unless the output stalls it, then squeeze
// out freed slots, one gap per cycle, then hand over the final result, if any.
// Fired ids leave one per cycle during the rotation unless stalled; each is
// held back one step so the final one can carry the last marker. A stalled
// receiver pauses the rotation when a second result is waiting. The input
// is stalled whenever an item is in progress.
// Reset empties the table and zeroes the id counter; no clearing pass.
// Depends on tet_pkg, tet_cell and timed_event_table_assert.svh.
`default_nettype none
`include "timed_event_table_assert.svh"
module timed_event_table import tet_pkg::*; #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 48
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic [47:0] now_ms_i,
  input  wire logic [31:0] period_ms_i,
  input  wire logic [15:0] repeat_budget_i,
  input  wire logic [31:0] target_id_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [31:0]      event_id_o,
  output logic             last_of_run_o
);
  localparam int CW    = (TIME_BITS > 48) ? TIME_BITS : 48;
  localparam int CNT_W = $clog2(SLOTS);
  localparam logic [CW:0] TMAX = (CW+1)'((65'd1 << TIME_BITS) - 65'd1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMPACT, S_FINISH} state_e;

  state_e                 state_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [2:0]             mode_q;
  logic [47:0]            now_q;
  logic [31:0]            target_q;
  logic                   hit_q;
  logic [31:0]            id_ctr_q;
  logic                   pend_valid_q;
  logic [2:0]             pend_status_q;
  logic [31:0]            pend_id_q;
  logic                   out_valid_q;
  logic [2:0]             out_status_q;
  logic [31:0]            out_id_q;
  logic                   out_last_q;

  logic                   v   [SLOTS];
  logic                   rep [SLOTS];
  logic [TIME_BITS-1:0]   due [SLOTS];
  logic [31:0]            ivl [SLOTS];
  logic [15:0]            bud [SLOTS];
  logic [31:0]            id  [SLOTS];
  cell_ctrl_t             ctrl [SLOTS];
  logic                   hole [SLOTS];

  function automatic logic [TIME_BITS-1:0] sat_add(logic [47:0] a, logic [31:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    return (s > TMAX) ? TMAX[TIME_BITS-1:0] : s[TIME_BITS-1:0];
  endfunction

  logic                 accept;
  logic                 out_free;
  logic                 is_tick;
  logic                 fire;
  logic                 step_ok;
  logic                 gap;
  logic                 ins_rep;
  logic                 ins_ok;
  logic                 tl_valid;
  logic [TIME_BITS-1:0] tl_due;
  logic [15:0]          tl_bud;
  logic [TIME_BITS-1:0] rearm;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign is_tick  = (mode_q == MODE_TICK);
  assign fire     = is_tick && v[0] && (CW'(now_q) >= CW'(due[0]));
  assign step_ok  = !(fire && pend_valid_q && !out_free);
  assign rearm    = sat_add(now_q, ivl[0]);
  assign ins_rep  = (mode_i == MODE_ADD_REP);
  assign ins_ok   = !(ins_rep && (period_ms_i == 32'd0)) && !v[SLOTS-1];

  always_comb begin
    tl_due = due[0];
    tl_bud = bud[0];
    if (is_tick) begin
      tl_valid = v[0] && !(fire && (!rep[0] || (bud[0] == 16'd1)));
      if (fire && rep[0]) begin
        tl_due = rearm;
        if (bud[0] != 16'd0) tl_bud = bud[0] - 16'd1;
      end
    end else begin
      tl_valid = v[0] && (id[0] != target_q);
    end
  end

  always_comb begin
    gap = 1'b0;
    for (int i = 0; i < SLOTS - 1; i++) begin
      if (!v[i] && v[i+1]) gap = 1'b1;
    end
    hole[0] = !v[0];
    for (int i = 1; i < SLOTS; i++) begin
      hole[i] = hole[i-1] || !v[i];
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      ctrl[i] = '0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            ctrl[i].clear  = (mode_i == MODE_CLEAR);
            ctrl[i].insert = ((mode_i == MODE_ADD_ONE) || ins_rep) && ins_ok && !v[i] &&
                             ((i == 0) || v[(i == 0) ? 0 : i-1]);
          end
        end
        S_SCAN:    ctrl[i].shift = step_ok;
        S_COMPACT: ctrl[i].shift = gap && hole[i];
        default:   ctrl[i] = '0;
      endcase
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    logic                 nb_v;
    logic [TIME_BITS-1:0] nb_due;
    logic [15:0]          nb_bud;
    if (g == SLOTS - 1) begin : g_tail
      assign nb_v   = (state_q == S_SCAN) ? tl_valid : 1'b0;
      assign nb_due = tl_due;
      assign nb_bud = tl_bud;
    end else begin : g_mid
      assign nb_v   = v[g+1];
      assign nb_due = due[g+1];
      assign nb_bud = bud[g+1];
    end
    tet_cell #(.TIME_BITS(TIME_BITS)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl[g]),
      .nb_valid_i (nb_v),
      .nb_rep_i   (rep[(g + 1) % SLOTS]),
      .nb_due_i   (nb_due),
      .nb_ivl_i   (ivl[(g + 1) % SLOTS]),
      .nb_bud_i   (nb_bud),
      .nb_id_i    (id[(g + 1) % SLOTS]),
      .ins_rep_i  (ins_rep),
      .ins_due_i  (sat_add(now_ms_i, period_ms_i)),
      .ins_ivl_i  (period_ms_i),
      .ins_bud_i  (ins_rep ? repeat_budget_i : 16'd0),
      .ins_id_i   (id_ctr_q),
      .valid_o    (v[g]),
      .rep_o      (rep[g]),
      .due_o      (due[g]),
      .ivl_o      (ivl[g]),
      .bud_o      (bud[g]),
      .id_o       (id[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      mode_q        <= MODE_ADD_ONE;
      hit_q         <= 1'b0;
      id_ctr_q      <= '0;
      pend_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
      now_q         <= '0;
      target_q      <= '0;
      pend_status_q <= ST_ADDED;
      pend_id_q     <= '0;
      out_status_q  <= ST_ADDED;
      out_id_q      <= '0;
      out_last_q    <= 1'b0;
    end else begin
      if (!out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            mode_q   <= mode_i;
            now_q    <= now_ms_i;
            target_q <= target_id_i;
            hit_q    <= 1'b0;
            cnt_q    <= '0;
            case (mode_i)
              MODE_ADD_ONE, MODE_ADD_REP: begin
                pend_valid_q <= 1'b1;
                pend_id_q    <= 32'd0;
                state_q      <= S_FINISH;
                if (ins_rep && (period_ms_i == 32'd0)) begin
                  pend_status_q <= ST_BAD_IVL;
                end else if (v[SLOTS-1]) begin
                  pend_status_q <= ST_FULL;
                end else begin
                  pend_status_q <= ST_ADDED;
                  pend_id_q     <= id_ctr_q;
                  id_ctr_q      <= id_ctr_q + 32'd1;
                end
              end
              MODE_REMOVE, MODE_TICK: state_q <= S_SCAN;
              MODE_CLEAR: begin
                pend_valid_q  <= 1'b1;
                pend_status_q <= ST_CLEARED;
                pend_id_q     <= 32'd0;
                state_q       <= S_FINISH;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (step_ok) begin
            cnt_q <= cnt_q + 1'b1;
            if (!is_tick && v[0] && (id[0] == target_q)) hit_q <= 1'b1;
            if (fire) begin
              if (pend_valid_q) begin
                out_valid_q  <= 1'b1;
                out_status_q <= pend_status_q;
                out_id_q     <= pend_id_q;
                out_last_q   <= 1'b0;
              end
              pend_valid_q  <= 1'b1;
              pend_status_q <= ST_FIRED;
              pend_id_q     <= id[0];
            end
            if (cnt_q == CNT_W'(SLOTS - 1)) state_q <= S_COMPACT;
          end
        end
        S_COMPACT: begin
          if (!gap) begin
            if (is_tick) begin
              state_q <= pend_valid_q ? S_FINISH : S_IDLE;
            end else begin
              pend_valid_q  <= 1'b1;
              pend_status_q <= hit_q ? ST_REMOVED : ST_NOT_FOUND;
              pend_id_q     <= target_q;
              state_q       <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= pend_status_q;
            out_id_q     <= pend_id_q;
            out_last_q   <= 1'b1;
            pend_valid_q <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign event_id_o    = out_id_q;
  assign last_of_run_o = out_last_q;

  `TET_ASSERT_IMPL(a_finish_pend, state_q == S_FINISH, pend_valid_q, "finish without result")
  `TET_ASSERT_IMPL(a_idle_prefix, state_q == S_IDLE, !gap, "table not compacted in idle")
  `TET_ASSERT_IMPL(a_idle_empty, state_q == S_IDLE, !pend_valid_q, "result left pending")
  `TET_ASSERT(a_no_overrun, (out_valid_q && out_stall_i) |=> out_valid_q, "result dropped")
endmodule
`default_nettype wire
